// File: hdl/lurt_pkg.sv
`timescale 1ns / 1ps
package lurt_pkg;

  localparam int unsigned CH_W         = 8;
  localparam int unsigned OUT_W        = 16;
  localparam int unsigned CH_VALUES    = 256;
  localparam int unsigned MAX_LEN_DEF  = 65535;
  localparam int unsigned ALPHABET_DEF = 256;

  // lookup stage control handed to the update stage
  typedef struct packed {
    logic vld;
    logic start;
  } lurt_s1_ctl_t;

endpackage

// File: hdl/lurt_if.sv
`timescale 1ns / 1ps
interface lurt_in_if
  import lurt_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            start_req;

  modport source (output valid, output ch, output start_req, input ready);
  modport sink (input valid, input ch, input start_req, output ready);
endinterface

interface lurt_out_if
  import lurt_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] run_len;
  logic [OUT_W-1:0] best_len;
  logic             overflow;

  modport source (output valid, output run_len, output best_len, output overflow,
                  input ready);
  modport sink (input valid, input run_len, input best_len, input overflow,
                output ready);
endinterface

// File: hdl/lurt_ram.sv
`timescale 1ns / 1ps
module lurt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/lurt_core.sv
`timescale 1ns / 1ps
module lurt_core
  import lurt_pkg::*;
#(
  parameter int unsigned MAX_LEN  = MAX_LEN_DEF,
  parameter int unsigned ALPHABET = ALPHABET_DEF,
  localparam int unsigned POS_W   = $clog2(MAX_LEN + 1),
  localparam int unsigned AW      = $clog2(ALPHABET)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lurt_s1_ctl_t      s1_ctl,
  input  logic [AW-1:0]     s1_addr,
  input  logic [POS_W-1:0]  ram_rdata,
  output logic              adv,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [POS_W-1:0]  ram_wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  run_len,
  output logic [OUT_W-1:0]  best_len,
  output logic              overflow
);

  logic [POS_W-1:0]    pos_r, head_r, run_r, best_r;
  logic [POS_W-1:0]    pos_nxt, head_nxt, run_nxt, best_nxt;
  logic                ovf_r, ovf_nxt;
  logic [ALPHABET-1:0] seen_r, seen_nxt;
  logic                fwd_vld_r;
  logic [AW-1:0]       fwd_addr_r;
  logic [POS_W-1:0]    fwd_data_r;
  logic                out_vld_r;
  logic [OUT_W-1:0]    run_out_r, best_out_r;
  logic                ovf_out_r;
  logic [OUT_W-1:0]    run_sat, best_sat;

  logic [POS_W-1:0]    pos_c, head_c, run_c, best_c, last_pos;
  logic                full, hit;

  assign adv = s1_ctl.vld && (!out_vld_r || out_ready);

  always_comb begin
    pos_c    = s1_ctl.start ? '0 : pos_r;
    head_c   = s1_ctl.start ? '0 : head_r;
    run_c    = s1_ctl.start ? '0 : run_r;
    best_c   = s1_ctl.start ? '0 : best_r;
    ovf_nxt  = s1_ctl.start ? 1'b0 : ovf_r;
    seen_nxt = s1_ctl.start ? '0 : seen_r;
    // write of the previous transaction lands on the same edge as this read
    last_pos = (fwd_vld_r && fwd_addr_r == s1_addr) ? fwd_data_r : ram_rdata;
    full     = pos_c >= POS_W'(MAX_LEN);
    hit      = seen_nxt[s1_addr] && (last_pos >= head_c);
    pos_nxt  = pos_c;
    head_nxt = head_c;
    run_nxt  = run_c;
    best_nxt = best_c;
    if (full) begin
      ovf_nxt = 1'b1;
    end else begin
      if (hit) begin
        run_nxt  = pos_c - last_pos;
        head_nxt = last_pos + POS_W'(1);
      end else begin
        run_nxt = run_c + POS_W'(1);
      end
      if (run_nxt > best_c) begin
        best_nxt = run_nxt;
      end
      seen_nxt[s1_addr] = 1'b1;
      pos_nxt = pos_c + POS_W'(1);
    end
  end

  assign ram_we    = adv && !full;
  assign ram_waddr = s1_addr;
  assign ram_wdata = pos_c;

  generate
    if (POS_W > OUT_W) begin : g_sat
      assign run_sat  = (|run_nxt[POS_W-1:OUT_W]) ? '1 : run_nxt[OUT_W-1:0];
      assign best_sat = (|best_nxt[POS_W-1:OUT_W]) ? '1 : best_nxt[OUT_W-1:0];
    end else begin : g_nosat
      assign run_sat  = OUT_W'(run_nxt);
      assign best_sat = OUT_W'(best_nxt);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      head_r    <= '0;
      run_r     <= '0;
      best_r    <= '0;
      ovf_r     <= 1'b0;
      seen_r    <= '0;
      fwd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        pos_r     <= pos_nxt;
        head_r    <= head_nxt;
        run_r     <= run_nxt;
        best_r    <= best_nxt;
        ovf_r     <= ovf_nxt;
        seen_r    <= seen_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (ram_we) begin
        fwd_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= pos_c;
    end
    if (adv) begin
      run_out_r  <= run_sat;
      best_out_r <= best_sat;
      ovf_out_r  <= ovf_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign run_len   = run_out_r;
  assign best_len  = best_out_r;
  assign overflow  = ovf_out_r;

endmodule

// File: hdl/longest_unique_run_tracker.sv
`timescale 1ns / 1ps
// channel   | dir | payload                         | handshake
// in_chan   | in  | ch[7:0], start_req              | valid/ready
// out_chan  | out | run_len[15:0], best_len[15:0],  | valid/ready
//           |     | overflow                        |
// one transaction per cycle sustained while out_chan is not stalled; the ram read
// issues on the accepting edge and the update stage registers the result to out_chan
// a ram write on the same edge as the next read is forwarded from a register
// synchronous reset clears the counters and the seen bits; the ram needs no clearing
// an output stall holds the update stage and, with that stage full, the input
module longest_unique_run_tracker
  import lurt_pkg::*;
#(
  parameter int unsigned MAX_LEN  = MAX_LEN_DEF,
  parameter int unsigned ALPHABET = ALPHABET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lurt_in_if.sink     in_chan,
  lurt_out_if.source  out_chan
);

  localparam int unsigned POS_W = $clog2(MAX_LEN + 1);
  localparam int unsigned AW    = $clog2(ALPHABET);

  logic [AW-1:0]    fold_tbl [CH_VALUES];
  logic             s1_vld_r, s1_start_r;
  logic [AW-1:0]    s1_addr_r;
  lurt_s1_ctl_t     s1_ctl;
  logic             accept, adv, in_ready;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [POS_W-1:0] ram_wdata, ram_rdata;

  // character folded into the alphabet
  generate
    for (genvar g = 0; g < CH_VALUES; g++) begin : g_fold
      assign fold_tbl[g] = AW'(g % ALPHABET);
    end
  endgenerate

  assign in_ready      = rst_n && (!s1_vld_r || adv);
  assign in_chan.ready = in_ready;
  assign accept        = in_chan.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
    end else if (adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r  <= fold_tbl[in_chan.ch];
      s1_start_r <= in_chan.start_req;
    end
  end

  assign s1_ctl.vld   = s1_vld_r;
  assign s1_ctl.start = s1_start_r;

  lurt_ram #(
    .WIDTH (POS_W),
    .DEPTH (ALPHABET)
  ) u_last_pos (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (fold_tbl[in_chan.ch]),
    .rdata (ram_rdata)
  );

  lurt_core #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_ctl    (s1_ctl),
    .s1_addr   (s1_addr_r),
    .ram_rdata (ram_rdata),
    .adv       (adv),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .run_len   (out_chan.run_len),
    .best_len  (out_chan.best_len),
    .overflow  (out_chan.overflow)
  );

endmodule
